FILE: rtl/drps_pkg.sv
`timescale 1ns / 1ps

package drps_pkg;

   localparam int NUM_RANKS      = 2;
   localparam int NUM_BANKGROUPS = 4;
   localparam int NUM_BANKS      = 4;
   localparam int QUEUE_DEPTH    = 32;

   localparam int SLOT_COUNT = NUM_RANKS * NUM_BANKGROUPS * NUM_BANKS;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int POS_W      = $clog2(QUEUE_DEPTH);
   localparam int SLOT_SUM_W = 16;

   // fixed field widths
   localparam int ARRIVE_W   = 32;
   localparam int TIME_W     = ARRIVE_W + 1;
   localparam int DIST_W     = 8;
   localparam int DELAY_W    = 16;
   localparam int COUNT_W    = 8;
   localparam int WIN_IDX_W  = 5;
   localparam int CSR_DATA_W = 64;
   localparam int NUM_LEVELS = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [31:0] PREF_THRESHOLDS_RST = 32'd269224964;
   localparam logic [63:0] PREF_DELAYS_RST     = 64'd450365116750234000;
   localparam logic [7:0]  STARVE_LIMIT_RST    = 8'd6;
   localparam logic        ONLY_LIMIT_PF_RST   = 1'b0;

   typedef enum logic [1:0] {
      CSR_PREF_THRESHOLDS = 2'd0,
      CSR_PREF_DELAYS     = 2'd1,
      CSR_STARVE_LIMIT    = 2'd2,
      CSR_ONLY_LIMIT_PF   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic ready;
      logic row_hit;
      logic prefetch;
      logic strict;
      logic starve;
   } cand_flags_type;

endpackage

FILE: rtl/dram_request_picker_with_starvation_core.sv
`timescale 1ns / 1ps

// DRAM request picker: one queue entry per req beat, one beat per clock when rsp is not
// stalled. Each entry is held in an input register, then a single compare stage
// ranks it against the kept candidate (ready, strict priority, bank starvation flag,
// oldest effective enqueue time, earlier entry on a tie). The entry that ends a scan
// (last_entry, or position QUEUE_DEPTH-1) loads the winner into the rsp register as it
// leaves the compare stage; in the same cycle a ready winner's bank row-hit counter is
// updated, and the next scan already sees it. The per-bank counters are flip-flops
// cleared by reset, so the block is usable right after reset. req stalls only when a
// scan-ending entry finds a full, stalled rsp register.
module dram_request_picker_with_starvation_core
   import drps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_wr_en,
   input  logic [1:0]             csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_ready_req,
   input  logic                   req_row_hit,
   input  logic                   req_is_prefetch,
   input  logic                   req_strict_priority,
   input  logic [ARRIVE_W-1:0]    req_arrive_cycle,
   input  logic [DIST_W-1:0]      req_pf_distance,
   input  logic                   req_rank_id,
   input  logic [1:0]             req_bankgroup_id,
   input  logic [1:0]             req_bank_id,
   input  logic                   req_last_entry,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [WIN_IDX_W-1:0]   rsp_winner_index,
   output logic                   rsp_winner_ready,
   output logic                   rsp_winner_row_hit
);

   // configuration
   logic [31:0]          pref_thr_ff;
   logic [63:0]          pref_dly_ff;
   logic [7:0]           starve_limit_ff;
   logic                 only_pf_ff;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic                 in_ready_ff, in_hit_ff, in_pf_ff, in_strict_ff, in_last_ff;
   logic [ARRIVE_W-1:0]  in_arrive_ff;
   logic [DIST_W-1:0]    in_dist_ff;
   logic                 in_rank_ff;
   logic [1:0]           in_bg_ff, in_bank_ff;

   // scan state
   logic [POS_W-1:0]     scan_pos_ff, scan_pos_in;
   logic [POS_W-1:0]     best_index_ff, best_index_in;
   cand_flags_type       best_flags_ff, best_flags_in;
   logic [TIME_W-1:0]    best_time_ff, best_time_in;
   logic [SLOT_W-1:0]    best_slot_ff, best_slot_in;
   logic [COUNT_W-1:0]   best_count_ff, best_count_in;

   logic [COUNT_W-1:0]   count_ff [SLOT_COUNT];

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WIN_IDX_W-1:0] rsp_index_ff;
   logic                 rsp_ready_ff, rsp_hit_ff;

   logic                 req_fire, stage_fire, scan_end, out_free;
   logic [SLOT_SUM_W-1:0] slot_sum;
   logic [SLOT_W-1:0]    new_slot;
   logic [COUNT_W-1:0]   new_count;
   cand_flags_type       new_flags;
   logic [DELAY_W-1:0]   add_delay;
   logic [TIME_W-1:0]    new_time;
   logic                 take_new;
   logic                 win_counts;
   cand_flags_type       win_flags;
   logic [SLOT_W-1:0]    win_slot;
   logic [COUNT_W-1:0]   win_count;
   logic [POS_W-1:0]     win_index;

   // handshake
   assign scan_end   = in_last_ff || (scan_pos_ff == POS_W'(QUEUE_DEPTH - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign stage_fire = in_valid_ff && (!scan_end || out_free);
   assign req_stall  = in_valid_ff && scan_end && !out_free;
   assign req_fire   = req_valid && !req_stall;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (stage_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // candidate evaluation
   always_comb begin
      slot_sum = SLOT_SUM_W'(in_bank_ff)
               + SLOT_SUM_W'(NUM_BANKS) * SLOT_SUM_W'(in_bg_ff)
               + SLOT_SUM_W'(NUM_BANKS * NUM_BANKGROUPS) * SLOT_SUM_W'(in_rank_ff);
      new_slot  = SLOT_W'(slot_sum % SLOT_COUNT);
      new_count = count_ff[new_slot];

      new_flags.ready    = in_ready_ff;
      new_flags.row_hit  = in_hit_ff;
      new_flags.prefetch = in_pf_ff;
      new_flags.strict   = in_strict_ff;
      new_flags.starve   = ((new_count >= starve_limit_ff) != in_hit_ff)
                           || (only_pf_ff && !in_pf_ff);

      // prefetches are pushed back by a delay picked from the distance thresholds
      priority if (!in_pf_ff || in_dist_ff < pref_thr_ff[7:0]) begin
         add_delay = '0;
      end else if (in_dist_ff < pref_thr_ff[15:8]) begin
         add_delay = pref_dly_ff[15:0];
      end else if (in_dist_ff < pref_thr_ff[23:16]) begin
         add_delay = pref_dly_ff[31:16];
      end else if (in_dist_ff < pref_thr_ff[31:24]) begin
         add_delay = pref_dly_ff[47:32];
      end else begin
         add_delay = pref_dly_ff[63:48];
      end
      new_time = TIME_W'(in_arrive_ff) + TIME_W'(add_delay);

      priority if (scan_pos_ff == '0) begin
         take_new = 1'b1;
      end else if (new_flags.ready != best_flags_ff.ready) begin
         take_new = new_flags.ready;
      end else if (new_flags.strict != best_flags_ff.strict) begin
         take_new = new_flags.strict;
      end else if (new_flags.starve != best_flags_ff.starve) begin
         take_new = new_flags.starve;
      end else begin
         take_new = new_time < best_time_ff;
      end

      win_flags = take_new ? new_flags : best_flags_ff;
      win_slot  = take_new ? new_slot  : best_slot_ff;
      win_count = take_new ? new_count : best_count_ff;
      win_index = take_new ? scan_pos_ff : best_index_ff;
      win_counts = win_flags.row_hit && (!only_pf_ff || win_flags.prefetch);

      best_flags_in = best_flags_ff;
      best_slot_in  = best_slot_ff;
      best_count_in = best_count_ff;
      best_index_in = best_index_ff;
      best_time_in  = best_time_ff;
      scan_pos_in   = scan_pos_ff;
      if (stage_fire) begin
         best_flags_in = win_flags;
         best_slot_in  = win_slot;
         best_count_in = win_count;
         best_index_in = win_index;
         best_time_in  = take_new ? new_time : best_time_ff;
         scan_pos_in   = scan_end ? '0 : scan_pos_ff + 1'b1;
      end

      if (stage_fire && scan_end) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pref_thr_ff     <= PREF_THRESHOLDS_RST;
         pref_dly_ff     <= PREF_DELAYS_RST;
         starve_limit_ff <= STARVE_LIMIT_RST;
         only_pf_ff      <= ONLY_LIMIT_PF_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PREF_THRESHOLDS: pref_thr_ff     <= csr_wr_data[31:0];
            CSR_PREF_DELAYS:     pref_dly_ff     <= csr_wr_data[63:0];
            CSR_STARVE_LIMIT:    starve_limit_ff <= csr_wr_data[7:0];
            CSR_ONLY_LIMIT_PF:   only_pf_ff      <= csr_wr_data[0];
            default:             only_pf_ff      <= only_pf_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         scan_pos_ff   <= '0;
         best_index_ff <= '0;
         best_flags_ff <= '0;
         best_time_ff  <= '0;
         best_slot_ff  <= '0;
         best_count_ff <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         scan_pos_ff   <= scan_pos_in;
         best_index_ff <= best_index_in;
         best_flags_ff <= best_flags_in;
         best_time_ff  <= best_time_in;
         best_slot_ff  <= best_slot_in;
         best_count_ff <= best_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ready_ff  <= req_ready_req;
         in_hit_ff    <= req_row_hit;
         in_pf_ff     <= req_is_prefetch;
         in_strict_ff <= req_strict_priority;
         in_arrive_ff <= req_arrive_cycle;
         in_dist_ff   <= req_pf_distance;
         in_rank_ff   <= req_rank_id;
         in_bg_ff     <= req_bankgroup_id;
         in_bank_ff   <= req_bank_id;
         in_last_ff   <= req_last_entry;
      end
      if (stage_fire && scan_end) begin
         rsp_index_ff <= WIN_IDX_W'(win_index);
         rsp_ready_ff <= win_flags.ready;
         rsp_hit_ff   <= win_flags.row_hit;
      end
   end

   // per-bank row-hit counters, updated once per scan for a ready winner
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            count_ff[i] <= '0;
         end
      end else if (stage_fire && scan_end && win_flags.ready) begin
         if (!win_counts) begin
            count_ff[win_slot] <= '0;
         end else if (win_count != COUNT_MAX) begin
            count_ff[win_slot] <= win_count + 1'b1;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_winner_index   = rsp_index_ff;
   assign rsp_winner_ready   = rsp_ready_ff;
   assign rsp_winner_row_hit = rsp_hit_ff;

`ifndef SYNTHESIS
   a_scan_restart: assert property (@(posedge clock) disable iff (reset)
      (stage_fire && scan_end) |=> (scan_pos_ff == '0 && rsp_valid_ff))
      else $error("scan did not restart after a result");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("req stalled without a blocked result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(stage_fire && scan_end))
      else $error("pending result overwritten");
`endif

endmodule
